@@ rtl/lsbr_pkg.sv @@
// lsbr_pkg: shared types, constants and helpers for the lsb-first bitstream reader
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package lsbr_pkg;

	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int MAX_FIELD_W = 32;
	localparam int MAX_BYTES   = 4;
	// widest field at bit offset 7 touches this many bytes
	localparam int SPAN_BYTES  = (7 + MAX_FIELD_W + 7) / 8;
	localparam int ACC_W       = SPAN_BYTES * 8;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_SEEK    = 3'd1,
		OP_BIT_LSB = 3'd2,
		OP_BIT_MSB = 3'd3,
		OP_UINT    = 3'd4,
		OP_SINT    = 3'd5,
		OP_ALIGN   = 3'd6,
		OP_NUMBER  = 3'd7
	} op_t;

	localparam logic [7:0] LSB_MASK [8] = '{8'h01, 8'h02, 8'h04, 8'h08,
	                                         8'h10, 8'h20, 8'h40, 8'h80};
	localparam logic [7:0] MSB_MASK [8] = '{8'h80, 8'h40, 8'h20, 8'h10,
	                                         8'h08, 8'h04, 8'h02, 8'h01};

	typedef struct packed {
		logic accept;
		logic issue;
		logic fin;
	} lsbr_cmd_t;

	typedef struct packed {
		logic nb_zero;
		logic last_issue;
	} lsbr_status_t;

	// low w bits set, w in 0..32
	function automatic logic [31:0] field_mask(input logic [5:0] w);
		logic [32:0] m;
		m = (33'd1 << w) - 33'd1;
		return m[31:0];
	endfunction

endpackage

@@ rtl/lsbr_ram.sv @@
// lsbr_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lsbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lsbr_ctrl.sv @@
// lsbr_ctrl: controller state machine sequencing byte reads for one op
// depends on lsbr_pkg
`timescale 1ns / 1ps

module lsbr_ctrl import lsbr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	output logic         done,
	output lsbr_cmd_t    cmd,
	input  lsbr_status_t status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= status.nb_zero ? S_FIN : S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (status.last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				// last read byte lands in the accumulator here
				S_DRAIN: state_q <= S_FIN;
				S_FIN:   state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign cmd.accept = start && (state_q == S_IDLE);
	assign cmd.issue  = (state_q == S_ISSUE);
	assign cmd.fin    = (state_q == S_FIN);

endmodule

@@ rtl/lsbr_dp.sv @@
// lsbr_dp: read position, byte store, byte accumulator and result registers
// depends on lsbr_pkg and lsbr_ram
`timescale 1ns / 1ps

module lsbr_dp import lsbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lsbr_cmd_t         cmd,
	output lsbr_status_t      status,
	input  logic [2:0]        op,
	input  logic [ADDR_W-1:0] addr,
	input  logic [7:0]        byte_val,
	input  logic [5:0]        width,
	output logic [31:0]       value,
	output logic [ADDR_W-1:0] byte_position,
	output logic [2:0]        bit_position
);

	logic [ADDR_W-1:0] ptr_q;
	logic [2:0]        bit_q;
	logic              cap_v_s1;

	op_t               op_q;
	logic [5:0]        wsat_q;
	logic [2:0]        bit_off_q;
	logic [ADDR_W-1:0] rd_base_q;
	logic [2:0]        nb_q;
	logic [2:0]        iss_k_q;
	logic [2:0]        cap_k_q;
	logic [ACC_W-1:0]  acc_q;
	logic [31:0]       value_q;
	logic [ADDR_W-1:0] byte_pos_q;
	logic [2:0]        bit_pos_q;

	op_t               op_in;
	logic [5:0]        wsat;
	logic [2:0]        cnt;
	logic [ADDR_W-1:0] aligned;
	logic [6:0]        field_total;
	logic [3:0]        bit_total;
	logic [2:0]        nb;
	logic [ADDR_W-1:0] nptr;
	logic [2:0]        nbit;
	logic [ADDR_W-1:0] base;
	logic [2:0]        off;
	logic [7:0]        rdata;
	logic [ADDR_W-1:0] raddr;

	logic [ACC_W-1:0]  shifted;
	logic [31:0]       fmask;
	logic [31:0]       fld;
	logic              sign_bit;
	logic              bit_lsb;
	logic              bit_msb;
	logic [31:0]       res;

	assign op_in       = op_t'(op);
	assign wsat        = (width > 6'(MAX_FIELD_W)) ? 6'(MAX_FIELD_W) : width;
	assign cnt         = (width > 6'(MAX_BYTES)) ? 3'(MAX_BYTES) : width[2:0];
	assign aligned     = (bit_q != 3'd0) ? ptr_q + ADDR_W'(1) : ptr_q;
	assign field_total = {4'd0, bit_q} + {1'b0, wsat};
	assign bit_total   = {1'b0, bit_q} + 4'd1;

	// next position and read plan, worked out in the accept cycle
	always_comb begin
		nb   = 3'd0;
		nptr = ptr_q;
		nbit = bit_q;
		base = ptr_q;
		off  = bit_q;
		unique case (op_in)
			OP_WRITE: begin
			end
			OP_SEEK: begin
				nptr = addr;
				nbit = 3'd0;
			end
			OP_BIT_LSB, OP_BIT_MSB: begin
				nb   = 3'd1;
				nptr = ptr_q + ADDR_W'(bit_total[3]);
				nbit = bit_total[2:0];
			end
			OP_UINT, OP_SINT: begin
				nb   = (wsat == 6'd0) ? 3'd0 : 3'((field_total + 7'd7) >> 3);
				nptr = ptr_q + ADDR_W'(field_total[6:3]);
				nbit = field_total[2:0];
			end
			OP_ALIGN: begin
				nptr = aligned;
				nbit = 3'd0;
			end
			OP_NUMBER: begin
				nb   = cnt;
				nptr = aligned + ADDR_W'(cnt);
				nbit = 3'd0;
				base = aligned;
				off  = 3'd0;
			end
		endcase
	end

	assign status.nb_zero    = (nb == 3'd0);
	assign status.last_issue = (iss_k_q == nb_q - 3'd1);

	assign raddr = rd_base_q + ADDR_W'(iss_k_q);

	lsbr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && (op_in == OP_WRITE)),
		.waddr(addr),
		.wdata(byte_val),
		.re   (cmd.issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			bit_q    <= '0;
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= cmd.issue;
			if (cmd.accept) begin
				ptr_q <= nptr;
				bit_q <= nbit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= op_in;
			wsat_q    <= wsat;
			bit_off_q <= off;
			rd_base_q <= base;
			nb_q      <= nb;
			iss_k_q   <= 3'd0;
			cap_k_q   <= 3'd0;
			acc_q     <= '0;
		end else begin
			if (cmd.issue) begin
				iss_k_q <= iss_k_q + 3'd1;
			end
			if (cap_v_s1) begin
				cap_k_q <= cap_k_q + 3'd1;
				// aligned numbers come first byte most significant
				if (op_q == OP_NUMBER) begin
					acc_q <= {acc_q[ACC_W-9:0], rdata};
				end else begin
					for (int i = 0; i < SPAN_BYTES; i++) begin
						if (cap_k_q == 3'(i)) begin
							acc_q[i*8 +: 8] <= rdata;
						end
					end
				end
			end
		end
		if (cmd.fin) begin
			value_q    <= res;
			byte_pos_q <= ptr_q;
			bit_pos_q  <= bit_q;
		end
	end

	assign shifted  = acc_q >> bit_off_q;
	assign fmask    = field_mask(wsat_q);
	assign fld      = shifted[31:0] & fmask;
	assign sign_bit = fld[5'(wsat_q - 6'd1)];
	assign bit_lsb  = |(acc_q[7:0] & LSB_MASK[bit_off_q]);
	assign bit_msb  = |(acc_q[7:0] & MSB_MASK[bit_off_q]);

	always_comb begin
		unique case (op_q)
			OP_BIT_LSB: res = {31'd0, bit_lsb};
			OP_BIT_MSB: res = {31'd0, bit_msb};
			OP_UINT:    res = fld;
			OP_SINT: begin
				// full-width and empty fields need no extension
				if ((wsat_q != 6'd0) && (wsat_q != 6'(MAX_FIELD_W)) && sign_bit) begin
					res = fld | ~fmask;
				end else begin
					res = fld;
				end
			end
			OP_NUMBER:  res = acc_q[31:0];
			default:    res = 32'd0;
		endcase
	end

	assign value         = value_q;
	assign byte_position = byte_pos_q;
	assign bit_position  = bit_pos_q;

endmodule

@@ rtl/lsb_first_bitstream_reader_core.sv @@
// lsb_first_bitstream_reader_core: top level joining controller and datapath
// depends on lsbr_pkg, lsbr_ctrl, lsbr_dp (and through it lsbr_ram)
//
//  channel   handshake       beat contents
//  -------   -------------   ----------------------------------------
//  command   start / busy    op, addr, byte_val, width
//  result    done (strobe)   value, byte_position, bit_position
//
// an op reading n stored bytes (n = 0..5) holds busy until it has finished, so
// no new op is accepted before it is through; with n of 0 (writes included) it
// goes straight to its finish state; the single read port of the byte store
// gives one byte a cycle and its read is registered.
// reset clears the read position to byte 0, bit 0; the store holds no reset.
// done is high for one cycle per op and cannot be held off by the receiver.
`timescale 1ns / 1ps

module lsb_first_bitstream_reader_core import lsbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [2:0]        op,
	input  logic [ADDR_W-1:0] addr,
	input  logic [7:0]        byte_val,
	input  logic [5:0]        width,
	output logic [31:0]       value,
	output logic [ADDR_W-1:0] byte_position,
	output logic [2:0]        bit_position
);

	lsbr_cmd_t    cmd;
	lsbr_status_t status;

	lsbr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.status(status)
	);

	lsbr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.op           (op),
		.addr         (addr),
		.byte_val     (byte_val),
		.width        (width),
		.value        (value),
		.byte_position(byte_position),
		.bit_position (bit_position)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted op did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an op is still in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> done)
		else $error("finished op gave no result");
`endif

endmodule
